// ----- design/mwms_pkg.sv -----
// shared types, operation codes and maze constants for the maze wall map store
// no dependencies
package mwms_pkg;

    localparam int MAZE_SIZE = 32;
    localparam int COORD_W   = 5;
    localparam int OP_W      = 3;
    localparam int SIDE_W    = 4;

    localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(MAZE_SIZE - 1);

    localparam logic [OP_W-1:0] OP_CLEAR_WALLS   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_REACHED = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_WALLS   = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_REACHED  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY         = 3'd4;

    // side bit positions, shared by dir_mask, wall_bits, walls and known_walls
    localparam int SIDE_WEST  = 0;
    localparam int SIDE_SOUTH = 1;
    localparam int SIDE_EAST  = 2;
    localparam int SIDE_NORTH = 3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [SIDE_W-1:0]  dir_mask;
        logic [SIDE_W-1:0]  wall_bits;
    } in_item_t;

    typedef struct packed {
        logic [SIDE_W-1:0] walls;
        logic [SIDE_W-1:0] known_walls;
        logic              cell_reached;
    } out_item_t;

    typedef logic [MAZE_SIZE-1:0] map_word_t;

endpackage

// ----- design/mwms_in_stage.sv -----
// input register for the maze wall map store
// depends on mwms_pkg
module mwms_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mwms_pkg::in_item_t s_data,
    input  logic              advance,
    output logic              item_valid,
    output mwms_pkg::in_item_t item
);
    import mwms_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // free, or emptying at this edge
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/mwms_map.sv -----
// wall and reached bitmaps with their write and query logic
// depends on mwms_pkg
module mwms_map (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               exec_en,
    input  mwms_pkg::in_item_t item,
    output mwms_pkg::out_item_t answer
);
    import mwms_pkg::*;

    map_word_t north_wall_rows_reg   [MAZE_SIZE-1];
    map_word_t east_wall_columns_reg [MAZE_SIZE-1];
    map_word_t reached_rows_reg      [MAZE_SIZE];

    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               at_west;
    logic               at_east;
    logic               at_south;
    logic               at_north;

    assign x        = item.cell_x;
    assign y        = item.cell_y;
    assign at_west  = (x == '0);
    assign at_east  = (x == COORD_LAST);
    assign at_south = (y == '0);
    assign at_north = (y == COORD_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAZE_SIZE - 1; i++) begin
                north_wall_rows_reg[i]   <= '0;
                east_wall_columns_reg[i] <= '0;
            end
            for (int i = 0; i < MAZE_SIZE; i++) begin
                reached_rows_reg[i] <= '0;
            end
        end else if (exec_en) begin
            unique case (item.op)
                OP_CLEAR_WALLS: begin
                    for (int i = 0; i < MAZE_SIZE - 1; i++) begin
                        north_wall_rows_reg[i]   <= '0;
                        east_wall_columns_reg[i] <= '0;
                    end
                end
                OP_CLEAR_REACHED: begin
                    for (int i = 0; i < MAZE_SIZE; i++) begin
                        reached_rows_reg[i] <= '0;
                    end
                end
                OP_WRITE_WALLS: begin
                    // sides on the outer edge are dropped
                    if (item.dir_mask[SIDE_NORTH] && !at_north) begin
                        north_wall_rows_reg[y][x] <= item.wall_bits[SIDE_NORTH];
                    end
                    if (item.dir_mask[SIDE_SOUTH] && !at_south) begin
                        north_wall_rows_reg[y - 1'b1][x] <= item.wall_bits[SIDE_SOUTH];
                    end
                    if (item.dir_mask[SIDE_EAST] && !at_east) begin
                        east_wall_columns_reg[x][y] <= item.wall_bits[SIDE_EAST];
                    end
                    if (item.dir_mask[SIDE_WEST] && !at_west) begin
                        east_wall_columns_reg[x - 1'b1][y] <= item.wall_bits[SIDE_WEST];
                    end
                end
                OP_MARK_REACHED: begin
                    reached_rows_reg[y][x] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // query lookup
    logic [SIDE_W-1:0] wall_side;
    logic [SIDE_W-1:0] nbr_reached;
    logic              here;

    always_comb begin
        here = reached_rows_reg[y][x];

        wall_side[SIDE_NORTH] = at_north || north_wall_rows_reg[y][x];
        wall_side[SIDE_SOUTH] = at_south || north_wall_rows_reg[y - 1'b1][x];
        wall_side[SIDE_EAST]  = at_east  || east_wall_columns_reg[x][y];
        wall_side[SIDE_WEST]  = at_west  || east_wall_columns_reg[x - 1'b1][y];

        nbr_reached[SIDE_NORTH] = !at_north && reached_rows_reg[y + 1'b1][x];
        nbr_reached[SIDE_SOUTH] = !at_south && reached_rows_reg[y - 1'b1][x];
        nbr_reached[SIDE_EAST]  = !at_east  && reached_rows_reg[y][x + 1'b1];
        nbr_reached[SIDE_WEST]  = !at_west  && reached_rows_reg[y][x - 1'b1];

        answer.walls        = wall_side;
        answer.known_walls  = wall_side | ~(nbr_reached | {SIDE_W{here}});
        answer.cell_reached = here;
    end

endmodule

// ----- design/mwms_out_stage.sv -----
// result register for the maze wall map store
// depends on mwms_pkg
module mwms_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  mwms_pkg::out_item_t answer,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output mwms_pkg::out_item_t m_data
);
    import mwms_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= answer;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- design/maze_wall_map_store.sv -----
// top level of the maze wall map store: input register, map, result register
// depends on mwms_pkg, mwms_in_stage, mwms_map, mwms_out_stage
//
//   channel | ports                         | carries
//   --------+-------------------------------+--------------------------------------
//   s_      | s_valid, s_ready, s_data      | op, cell_x, cell_y, dir_mask, wall_bits
//   m_      | m_valid, m_ready, m_data      | walls, known_walls, cell_reached
//
// one transaction a cycle sustained while no query waits on a stalled result register; a query is answered
// through the input register, then map lookup into the result register
// non-query transactions update the map in the cycle after acceptance and give no result
// the maps are flip-flops cleared by reset, so no clearing pass is needed
// a query only waits in the input register while the result register is stalled
module maze_wall_map_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mwms_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mwms_pkg::out_item_t m_data
);
    import mwms_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      out_free;
    logic      is_query;
    logic      advance;
    out_item_t answer;

    // only a query needs a slot in the result register
    assign is_query = (item.op == OP_QUERY);
    assign advance  = item_valid && (!is_query || out_free);

    mwms_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // map state changes exactly when the transaction leaves the input register
    mwms_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (advance),
        .item    (item),
        .answer  (answer)
    );

    mwms_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && is_query),
        .answer   (answer),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- design/mwms_checker.sv -----
// port-level checks for the maze wall map store, bound to the top level
// depends on mwms_pkg and maze_wall_map_store
module mwms_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mwms_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mwms_pkg::out_item_t m_data
);
    import mwms_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // empty and ready straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // input only backs up behind a stalled result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // a fresh result comes from a query that passed straight through the input register
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_data.op == OP_QUERY), 2))
        else $error("result without matching query");

endmodule

bind maze_wall_map_store mwms_checker u_mwms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
